// ===== hdl/graph_depth_first_order_assert.svh =====
// assertion macros for the depth-first order block
`ifndef GRAPH_DEPTH_FIRST_ORDER_ASSERT_SVH
`define GRAPH_DEPTH_FIRST_ORDER_ASSERT_SVH

`ifndef SYNTH

// expression must hold at every clock edge out of reset
`define GDFO_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define GDFO_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`else

`define GDFO_ASSERT_ALWAYS(label, expr, msg)
`define GDFO_ASSERT_IMPLIES(label, ante, cons, msg)

`endif

`endif

// ===== hdl/gdfo_pkg.sv =====
// shared constants, types and helpers for the depth-first order block
package gdfo_pkg;

	localparam int MAX_VERTICES = 32;
	localparam int VTX_W = 5;
	localparam int CNT_W = 6;

	typedef logic [MAX_VERTICES-1:0] vmask_t;
	typedef logic [VTX_W-1:0] vtx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_ADD = 2'd1;
	localparam logic [1:0] KIND_WALK = 2'd2;

	typedef struct packed {
		logic clear;
		logic add;
		vtx_t a;
		vtx_t b;
	} adj_cmd_t;

	// lowest set bit of a vertex mask
	function automatic vtx_t first_set(vmask_t m);
		vtx_t idx;
		idx = '0;
		for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
			if (m[i]) begin
				idx = vtx_t'(i);
			end
		end
		return idx;
	endfunction

endpackage

// ===== hdl/graph_depth_first_order.sv =====
// depth-first visit order over an adjacency bit matrix, top level
//
// Commands enter on start/kind/vertex_a/vertex_b and transfer at a clock edge
// with start high and busy low. Clear (kind 0) and add edge (kind 1) finish in
// the transfer cycle and keep busy low. Kind 3 is ignored. A traversal (kind 2)
// raises busy and emits one visited_vertex per vertex in use, each shown for
// exactly one cycle with visit_strobe high; last marks the final one, and busy
// drops in that same cycle. The receiver cannot stall the results.
// After the start transfer the block enters ROOT, which registers the first
// result; each visit is a pass of the find-first unit, each stack pop goes
// through the POP state and the stack ram read port, and each new root
// through ROOT. vertex_count is written by cfg_we/cfg_wdata; the user is to
// write it only while idle, as the block itself does not enforce this. Values
// above 32 saturate, and zero makes a traversal emit nothing. Reset clears all
// edges, sets vertex_count to 32 and returns the block to idle.
module graph_depth_first_order (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  logic [1:0]     kind,
	input  gdfo_pkg::vtx_t vertex_a,
	input  gdfo_pkg::vtx_t vertex_b,
	input  logic           cfg_we,
	input  gdfo_pkg::cnt_t cfg_wdata,
	output logic           visit_strobe,
	output gdfo_pkg::vtx_t visited_vertex,
	output logic           last
);

	import gdfo_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROOT,
		ST_SCAN,
		ST_POP
	} state_t;

	state_t   state_q;
	cnt_t     count_q;
	cnt_t     n_q;
	cnt_t     k_q;
	cnt_t     depth_q;
	vmask_t   valid_q;
	vmask_t   visited_q;
	vtx_t     u_q;

	adj_cmd_t adj_cmd;
	vmask_t   row;
	vmask_t   open_mask;
	vmask_t   cand;
	logic     hit;
	vtx_t     w;
	vmask_t   w_bit;
	logic     is_last;
	cnt_t     n_sat;
	vmask_t   n_mask;
	logic     stk_we;
	vtx_t     stk_waddr;
	cnt_t     depth_m2;
	vtx_t     stk_rdata;
	logic     accept;

	assign accept = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);

	always_comb begin
		adj_cmd.clear = accept && (kind == KIND_CLEAR);
		adj_cmd.add = accept && (kind == KIND_ADD);
		adj_cmd.a = vertex_a;
		adj_cmd.b = vertex_b;
	end

	gdfo_adj u_adj (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (adj_cmd),
		.rd_vertex (u_q),
		.rd_row    (row)
	);

	// shared find-first unit: roots in ROOT, neighbors in SCAN
	always_comb begin
		open_mask = valid_q & ~visited_q;
		cand = (state_q == ST_ROOT) ? open_mask : (row & open_mask);
		hit = |cand;
		w = first_set(cand);
		w_bit = vmask_t'(1) << w;
		is_last = (cnt_t'(k_q + 1'b1) == n_q);
		n_sat = (count_q > cnt_t'(MAX_VERTICES)) ? cnt_t'(MAX_VERTICES) : count_q;
		n_mask = '0;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			n_mask[i] = (cnt_t'(i) < n_sat);
		end
		stk_we = hit && ((state_q == ST_ROOT) ||
			((state_q == ST_SCAN) && (depth_q < cnt_t'(MAX_VERTICES))));
		stk_waddr = (state_q == ST_ROOT) ? '0 : depth_q[VTX_W-1:0];
		depth_m2 = depth_q - cnt_t'(2);
	end

	gdfo_ram #(
		.WIDTH (VTX_W),
		.DEPTH (MAX_VERTICES)
	) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (w),
		.raddr (depth_m2[VTX_W-1:0]),
		.rdata (stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= cnt_t'(MAX_VERTICES);
			n_q <= '0;
			k_q <= '0;
			depth_q <= '0;
			valid_q <= '0;
			visited_q <= '0;
			u_q <= '0;
			visit_strobe <= 1'b0;
			visited_vertex <= '0;
			last <= 1'b0;
		end else begin
			visit_strobe <= 1'b0;
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (kind == KIND_WALK)) begin
						visited_q <= '0;
						k_q <= '0;
						depth_q <= '0;
						n_q <= n_sat;
						valid_q <= n_mask;
						if (n_sat != '0) begin
							state_q <= ST_ROOT;
						end
					end
				end
				ST_ROOT: begin
					if (hit) begin
						visit_strobe <= 1'b1;
						visited_vertex <= w;
						last <= is_last;
						visited_q <= visited_q | w_bit;
						k_q <= cnt_t'(k_q + 1'b1);
						u_q <= w;
						depth_q <= cnt_t'(1);
						state_q <= is_last ? ST_IDLE : ST_SCAN;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (hit) begin
						visit_strobe <= 1'b1;
						visited_vertex <= w;
						last <= is_last;
						visited_q <= visited_q | w_bit;
						k_q <= cnt_t'(k_q + 1'b1);
						u_q <= w;
						if (depth_q < cnt_t'(MAX_VERTICES)) begin
							depth_q <= cnt_t'(depth_q + 1'b1);
						end
						state_q <= is_last ? ST_IDLE : ST_SCAN;
					end else begin
						depth_q <= cnt_t'(depth_q - 1'b1);
						state_q <= (depth_q == cnt_t'(1)) ? ST_ROOT : ST_POP;
					end
				end
				ST_POP: begin
					u_q <= stk_rdata;
					state_q <= ST_SCAN;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`include "graph_depth_first_order_assert.svh"

	`GDFO_ASSERT_ALWAYS(a_depth_bound, depth_q <= cnt_t'(MAX_VERTICES), "stack depth overflow")
	`GDFO_ASSERT_ALWAYS(a_count_match, cnt_t'($countones(visited_q)) == k_q, "visit count mismatch")
	`GDFO_ASSERT_IMPLIES(a_last_ends, visit_strobe && last, !busy, "busy after last vertex")
	`GDFO_ASSERT_IMPLIES(a_mid_busy, visit_strobe && !last, busy, "traversal ended early")
	`GDFO_ASSERT_IMPLIES(a_pop_depth, state_q == ST_POP, depth_q >= cnt_t'(1), "pop on empty stack")

endmodule

// ===== hdl/gdfo_ram.sv =====
// generic single write port ram with registered read
module gdfo_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/gdfo_adj.sv =====
// adjacency bit matrix with a clear of all rows at once and symmetric edge insert
module gdfo_adj (
	input  logic              clk,
	input  logic              arst_n,
	input  gdfo_pkg::adj_cmd_t cmd,
	input  gdfo_pkg::vtx_t    rd_vertex,
	output gdfo_pkg::vmask_t  rd_row
);

	import gdfo_pkg::*;

	vmask_t rows_q [MAX_VERTICES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_VERTICES; i++) begin
				rows_q[i] <= '0;
			end
		end else if (cmd.clear) begin
			for (int i = 0; i < MAX_VERTICES; i++) begin
				rows_q[i] <= '0;
			end
		end else if (cmd.add) begin
			// one update per row, a self loop sets a single bit
			for (int i = 0; i < MAX_VERTICES; i++) begin
				rows_q[i] <= rows_q[i]
					| ((vtx_t'(i) == cmd.a) ? (vmask_t'(1) << cmd.b) : vmask_t'(0))
					| ((vtx_t'(i) == cmd.b) ? (vmask_t'(1) << cmd.a) : vmask_t'(0));
			end
		end
	end

	assign rd_row = rows_q[rd_vertex];

endmodule

// ===== sim/tb.sv =====
// testbench for graph_depth_first_order with a local depth-first predictor
`timescale 1ns / 1ps

module tb;
	import gdfo_pkg::*;

	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam int SETTLE_CYCLES = 4;

	typedef struct packed {
		vtx_t vertex;
		logic last;
	} visit_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] kind;
	vtx_t vertex_a;
	vtx_t vertex_b;
	logic cfg_we;
	cnt_t cfg_wdata;
	logic visit_strobe;
	vtx_t visited_vertex;
	logic last;

	vmask_t adj_model [MAX_VERTICES];
	cnt_t count_model;
	visit_t expected_visits [$];
	visit_t oldest_visit;
	int error_count;
	bit gaps_on;

	graph_depth_first_order u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.vertex_a(vertex_a),
		.vertex_b(vertex_b),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.visit_strobe(visit_strobe),
		.visited_vertex(visited_vertex),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("[graph_depth_first_order] ERROR");
		$finish;
	end

	task automatic report_mismatch(input string what);
		error_count++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	function automatic int lowest_vertex(vmask_t m);
		int idx;
		idx = 0;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			if (m[i]) begin
				idx = i;
				break;
			end
		end
		return idx;
	endfunction

	function automatic void note_visit(input int v, inout int emitted, input int n);
		visit_t item;
		item.vertex = vtx_t'(v);
		item.last = (emitted + 1 == n);
		expected_visits.push_back(item);
		emitted++;
	endfunction

	// explicit-stack walk from every unvisited root, neighbors in ascending order
	function automatic void predict_traversal();
		int n;
		int depth;
		int top;
		int w;
		int emitted;
		vmask_t valid;
		vmask_t seen;
		vmask_t cand;
		int stack_vtx [MAX_VERTICES];
		int stack_pos [MAX_VERTICES];
		n = (count_model > MAX_VERTICES) ? MAX_VERTICES : int'(count_model);
		valid = '0;
		seen = '0;
		emitted = 0;
		for (int i = 0; i < n; i++) valid[i] = 1'b1;
		for (int s = 0; s < n; s++) begin
			if (!seen[s]) begin
				seen[s] = 1'b1;
				note_visit(s, emitted, n);
				stack_vtx[0] = s;
				stack_pos[0] = 0;
				depth = 1;
				while (depth > 0) begin
					top = depth - 1;
					cand = adj_model[stack_vtx[top]] & valid & ~seen;
					for (int i = 0; i < stack_pos[top] && i < MAX_VERTICES; i++) cand[i] = 1'b0;
					if (cand == '0) begin
						depth--;
					end else begin
						w = lowest_vertex(cand);
						stack_pos[top] = w + 1;
						seen[w] = 1'b1;
						note_visit(w, emitted, n);
						if (depth < MAX_VERTICES) begin
							stack_vtx[depth] = w;
							stack_pos[depth] = 0;
							depth++;
						end
					end
				end
			end
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && visit_strobe) begin
			if (expected_visits.size() == 0) begin
				report_mismatch($sformatf("visit %0d with none expected", visited_vertex));
			end else begin
				oldest_visit = expected_visits.pop_front();
				if (visited_vertex !== oldest_visit.vertex)
					report_mismatch($sformatf("visited_vertex %0d, expected %0d",
						visited_vertex, oldest_visit.vertex));
				if (last !== oldest_visit.last)
					report_mismatch($sformatf("last %b on vertex %0d, expected %b",
						last, oldest_visit.vertex, oldest_visit.last));
			end
		end
	end

	// one command transfer; start stays high so the next command can follow at once
	task automatic send_cmd(input logic [1:0] k, input vtx_t a, input vtx_t b);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		vertex_a <= a;
		vertex_b <= b;
		do @(posedge clk); while (busy);
		case (k)
			KIND_CLEAR: begin
				for (int i = 0; i < MAX_VERTICES; i++) adj_model[i] = '0;
			end
			KIND_ADD: begin
				adj_model[a][b] = 1'b1;
				adj_model[b][a] = 1'b1;
			end
			KIND_WALK: predict_traversal();
			default: ;
		endcase
	endtask

	task automatic drain();
		start <= 1'b0;
		while (expected_visits.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic set_vertex_count(input cnt_t v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		count_model = v;
	endtask

	function automatic vtx_t pick_vertex();
		int n;
		n = (count_model > MAX_VERTICES) ? MAX_VERTICES : int'(count_model);
		if (n == 0 || $urandom_range(0, 7) == 0) return vtx_t'($urandom_range(0, 31));
		return vtx_t'($urandom_range(0, n - 1));
	endfunction

	task automatic test_reset_count();
		send_cmd(KIND_WALK, '0, '0);
	endtask

	task automatic test_edge_cases();
		send_cmd(KIND_ADD, 5'd0, 5'd31);
		send_cmd(KIND_ADD, 5'd31, 5'd5);
		send_cmd(KIND_ADD, 5'd5, 5'd5);
		send_cmd(KIND_ADD, 5'd3, 5'd7);
		send_cmd(KIND_ADD, 5'd7, 5'd3);
		send_cmd(KIND_ADD, 5'd10, 5'd20);
		send_cmd(KIND_NONE, 5'd31, 5'd31);
		send_cmd(KIND_WALK, 5'd31, 5'd0);
		send_cmd(KIND_CLEAR, 5'd31, 5'd31);
		send_cmd(KIND_WALK, '0, '0);
	endtask

	task automatic test_count_limits();
		set_vertex_count(6'd0);
		send_cmd(KIND_ADD, 5'd0, 5'd1);
		send_cmd(KIND_WALK, '0, '0);
		set_vertex_count(6'd1);
		send_cmd(KIND_WALK, '0, '0);
		set_vertex_count(6'd63);
		send_cmd(KIND_ADD, 5'd2, 5'd9);
		send_cmd(KIND_NONE, 5'd0, 5'd0);
		send_cmd(KIND_WALK, '0, '0);
		set_vertex_count(6'd4);
		send_cmd(KIND_ADD, 5'd2, 5'd20);
		send_cmd(KIND_ADD, 5'd1, 5'd3);
		send_cmd(KIND_WALK, '0, '0);
	endtask

	// one long path through all vertices in shuffled order builds a deep stack
	task automatic test_deep_path();
		int perm [MAX_VERTICES];
		int j;
		int t;
		set_vertex_count(6'd32);
		for (int i = 0; i < MAX_VERTICES; i++) perm[i] = i;
		for (int i = MAX_VERTICES - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = perm[i];
			perm[i] = perm[j];
			perm[j] = t;
		end
		send_cmd(KIND_CLEAR, '0, '0);
		for (int i = 0; i < MAX_VERTICES - 1; i++)
			send_cmd(KIND_ADD, vtx_t'(perm[i]), vtx_t'(perm[i + 1]));
		send_cmd(KIND_WALK, '0, '0);
	endtask

	task automatic test_random_graphs();
		cnt_t cnt;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: cnt = 6'd32;
				1: cnt = 6'd2;
				2: cnt = 6'd63;
				4: cnt = 6'd1;
				5: cnt = cnt_t'($urandom_range(33, 63));
				7: cnt = 6'd16;
				default: cnt = cnt_t'($urandom_range(1, 32));
			endcase
			set_vertex_count(cnt);
			repeat ($urandom_range(1, 2)) begin
				if ($urandom_range(0, 1)) send_cmd(KIND_CLEAR, vtx_t'($urandom), vtx_t'($urandom));
				repeat ($urandom_range(1, 10)) begin
					if ($urandom_range(0, 9) == 0)
						send_cmd(KIND_NONE, vtx_t'($urandom), vtx_t'($urandom));
					else
						send_cmd(KIND_ADD, pick_vertex(), pick_vertex());
				end
				send_cmd(KIND_WALK, vtx_t'($urandom), vtx_t'($urandom));
			end
		end
	endtask

	task automatic test_back_to_back();
		gaps_on = 1'b0;
		set_vertex_count(cnt_t'($urandom_range(8, 32)));
		send_cmd(KIND_CLEAR, '0, '0);
		repeat (12) send_cmd(KIND_ADD, pick_vertex(), pick_vertex());
		repeat (3) send_cmd(KIND_WALK, '0, '0);
		send_cmd(KIND_ADD, pick_vertex(), pick_vertex());
		send_cmd(KIND_WALK, '0, '0);
	endtask

	initial begin
		start <= 1'b0;
		kind <= KIND_CLEAR;
		vertex_a <= '0;
		vertex_b <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		arst_n <= 1'b0;
		gaps_on = 1'b1;
		error_count = 0;
		count_model = 6'd32;
		for (int i = 0; i < MAX_VERTICES; i++) adj_model[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_count();
		test_edge_cases();
		test_count_limits();
		test_deep_path();
		test_random_graphs();
		test_back_to_back();

		drain();
		repeat (20) @(posedge clk);
		if (error_count == 0 && expected_visits.size() == 0) begin
			$display("[graph_depth_first_order] OK");
		end else begin
			$display("[graph_depth_first_order] ERROR");
		end
		$finish;
	end

endmodule
